>>> rtl/core/euler_xyz_to_quaternion_core_macros.svh
// Assertion macros shared by the euler-to-quaternion RTL
`ifndef EULER_XYZ_TO_QUATERNION_CORE_MACROS_SVH
`define EULER_XYZ_TO_QUATERNION_CORE_MACROS_SVH

// Implication checked every clock, disabled in reset
`define EQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked at the next clock, disabled in reset
`define EQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/eq_pkg.sv
package eq_pkg;

    // Working precision of the CORDIC and product datapath
    localparam int WORK_FRAC = 30;
    localparam int WORK_W    = 36;
    localparam int RED_W     = 36;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int OUT_FRAC_BITS_DEF   = 14;
    localparam int CORDIC_STAGES_DEF   = 16;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    localparam logic signed [RED_W-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [RED_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

    // Arctangent table, floor(atan(2^-i) * 2^30)
    function automatic logic signed [WORK_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [WORK_W-1:0] v;
        case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd7;
            5'd28: v = 36'sd3;
            5'd29: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // One CORDIC lane: residual angle, x, y and cosine sign
    typedef struct packed {
        logic signed [WORK_W-1:0] t;
        logic signed [WORK_W-1:0] x;
        logic signed [WORK_W-1:0] y;
        logic                     neg_cos;
    } t_lane;

    // Three lanes travel together through the cell row
    typedef struct packed {
        t_lane lx;
        t_lane ly;
        t_lane lz;
    } t_cell_data;

endpackage

>>> rtl/core/eq_cell.sv
// One CORDIC micro-rotation for all three angles, registered.
module eq_cell #(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  eq_pkg::t_cell_data    i_data,
    output logic                  o_valid,
    output eq_pkg::t_cell_data    o_data
);

    localparam logic [4:0] K = 5'(STAGE % 32);

    logic               r_valid;
    eq_pkg::t_cell_data r_data;
    eq_pkg::t_cell_data n_data;

    function automatic eq_pkg::t_lane rot(input eq_pkg::t_lane a);
        eq_pkg::t_lane r;
        r = a;
        if (a.t >= 0) begin
            r.x = a.x - (a.y >>> K);
            r.y = a.y + (a.x >>> K);
            r.t = a.t - eq_pkg::atan_q30(K);
        end else begin
            r.x = a.x + (a.y >>> K);
            r.y = a.y - (a.x >>> K);
            r.t = a.t + eq_pkg::atan_q30(K);
        end
        return r;
    endfunction

    always_comb begin
        n_data.lx = rot(i_data.lx);
        n_data.ly = rot(i_data.ly);
        n_data.lz = rot(i_data.lz);
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/core/eq_prep.sv
// Scales an input angle to a Q30 half angle, reduces to [-pi, pi], folds to +-pi/2.
module eq_prep #(
    parameter int ANGLE_FRAC_BITS = eq_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic signed [eq_pkg::IN_W-1:0] i_angle,
    output eq_pkg::t_lane                  o_lane
);

    localparam int SH = eq_pkg::WORK_FRAC - 1 - ANGLE_FRAC_BITS;
    // wide enough for the scaled angle and for the Q30 constants
    localparam int TW = (eq_pkg::IN_W + SH + 1 > eq_pkg::RED_W) ?
                        eq_pkg::IN_W + SH + 1 : eq_pkg::RED_W;
    // multiples of 2*pi to strip, 2^(NSTEP-1) down to 1
    localparam int NSTEP = (SH > 17) ? SH - 16 : 0;

    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] mag;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [TW-1:0] t3;

    always_comb begin
        t0 = TW'(i_angle) <<< SH;
        // truncating modulo of 2*pi by compare and subtract on the magnitude
        mag = (t0 < 0) ? -t0 : t0;
        for (int k = NSTEP - 1; k >= 0; k--) begin
            if (mag >= (TW'(eq_pkg::TWO_PI_Q30) <<< k)) begin
                mag = mag - (TW'(eq_pkg::TWO_PI_Q30) <<< k);
            end
        end
        t1 = (t0 < 0) ? -mag : mag;
        t2 = t1;
        if (t1 > eq_pkg::PI_Q30) begin
            t2 = t1 - eq_pkg::TWO_PI_Q30;
        end else if (t1 < -eq_pkg::PI_Q30) begin
            t2 = t1 + eq_pkg::TWO_PI_Q30;
        end
        t3             = t2;
        o_lane.neg_cos = 1'b0;
        if (t2 > eq_pkg::HALF_PI_Q30) begin
            t3             = eq_pkg::PI_Q30 - t2;
            o_lane.neg_cos = 1'b1;
        end else if (t2 < -eq_pkg::HALF_PI_Q30) begin
            t3             = -eq_pkg::PI_Q30 - t2;
            o_lane.neg_cos = 1'b1;
        end
        o_lane.t = t3[eq_pkg::WORK_W-1:0];
        o_lane.x = eq_pkg::GAIN_Q30;
        o_lane.y = '0;
    end

endmodule

>>> rtl/core/eq_compose.sv
// Hamilton products qz * (qy * qx), three registered stages.
module eq_compose #(
    parameter int OUT_FRAC_BITS = eq_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  eq_pkg::t_cell_data       i_data,
    output logic                     o_valid,
    output logic [4*eq_pkg::OUT_W-1:0] o_quat
);

    localparam int W  = eq_pkg::WORK_W;
    localparam int PW = 2 * W;
    localparam int SF = 2 * eq_pkg::WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [PW-1:0] HALF30 = PW'(64'sd1 <<< 29);
    localparam logic signed [PW-1:0] HALFO  = PW'(64'sd1 <<< (SF - 1));
    localparam logic signed [PW-1:0] LIM    = PW'(64'sd1 <<< OUT_FRAC_BITS);

    logic signed [W-1:0] cx, sx, cy, sy, cz, sz;
    logic [2:0]          r_valid;
    logic signed [W-1:0] r_r0, r_r1, r_r2, r_r3, r_cz, r_sz;
    logic signed [PW-1:0] r_q0, r_q1, r_q2, r_q3;
    logic signed [PW-1:0] p00, p01, p10, p11;

    function automatic logic signed [eq_pkg::OUT_W-1:0] fin(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] s;
        s = (v + HALFO) >>> SF;
        if (s > LIM) s = LIM;
        if (s < -LIM) s = -LIM;
        if (s > 64'sd32767) s = PW'(64'sd32767);
        if (s < -64'sd32768) s = PW'(-64'sd32768);
        return s[eq_pkg::OUT_W-1:0];
    endfunction

    always_comb begin
        cx = i_data.lx.neg_cos ? -i_data.lx.x : i_data.lx.x;
        cy = i_data.ly.neg_cos ? -i_data.ly.x : i_data.ly.x;
        cz = i_data.lz.neg_cos ? -i_data.lz.x : i_data.lz.x;
        sx = i_data.lx.y;
        sy = i_data.ly.y;
        sz = i_data.lz.y;
        p00 = (PW'(cy) * PW'(cx) + HALF30) >>> 30;
        p01 = (PW'(cy) * PW'(sx) + HALF30) >>> 30;
        p10 = (PW'(sy) * PW'(cx) + HALF30) >>> 30;
        p11 = (PW'(sy) * PW'(sx) + HALF30) >>> 30;
    end

    // qy*qx products, then qz products, then rounding and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        if (i_en) begin
            r_r0 <= p00[W-1:0];
            r_r1 <= p01[W-1:0];
            r_r2 <= p10[W-1:0];
            r_r3 <= -p11[W-1:0];
            r_cz <= cz;
            r_sz <= sz;
            r_q0 <= PW'(r_cz) * PW'(r_r0) - PW'(r_sz) * PW'(r_r3);
            r_q1 <= PW'(r_cz) * PW'(r_r1) - PW'(r_sz) * PW'(r_r2);
            r_q2 <= PW'(r_cz) * PW'(r_r2) + PW'(r_sz) * PW'(r_r1);
            r_q3 <= PW'(r_cz) * PW'(r_r3) + PW'(r_sz) * PW'(r_r0);
            o_quat <= {fin(r_q3), fin(r_q2), fin(r_q1), fin(r_q0)};
        end
    end

    assign o_valid = r_valid[2];

endmodule

>>> rtl/core/euler_xyz_to_quaternion_core.sv
// Euler x-y-z (extrinsic) angles to unit quaternion.
// Input stream: s_axis_tdata = {angle_z, angle_y, angle_x}, each signed Q3.13.
// Output stream: m_axis_tdata = {quat_z, quat_y, quat_x, quat_w}, each signed Q2.14,
// saturated to plus or minus one.
// Each angle is halved, range-reduced and folded, then passes a row of
// CORDIC_STAGES identical cells (one micro-rotation per cell, three lanes in
// parallel), then three product stages: qy*qx, qz*(qy*qx), round and clamp.
// Throughput: one item per cycle while the output is not stalled; the whole pipeline advances together.
// A stall on the output freezes the pipeline; tready upstream then follows
// downstream tready when the output register is full.
// Reset clears every valid bit; data registers are not reset.
// No state is kept between items.
module euler_xyz_to_quaternion_core #(
    parameter int ANGLE_FRAC_BITS = eq_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = eq_pkg::OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = eq_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // angle_x, angle_y, angle_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);

`include "euler_xyz_to_quaternion_core_macros.svh"

    logic                en;
    logic                n_out_valid;
    logic [CORDIC_STAGES:0] v_chain;
    eq_pkg::t_cell_data  d_chain [CORDIC_STAGES+1];

    // Advance whenever the output slot is free or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    eq_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_x (
        .i_angle(s_axis_tdata[15:0]),  .o_lane(d_chain[0].lx));
    eq_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_y (
        .i_angle(s_axis_tdata[31:16]), .o_lane(d_chain[0].ly));
    eq_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_z (
        .i_angle(s_axis_tdata[47:32]), .o_lane(d_chain[0].lz));
    assign v_chain[0] = s_axis_tvalid;

    // Row of CORDIC cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        eq_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(v_chain[g]),
            .i_data (d_chain[g]),
            .o_valid(v_chain[g+1]),
            .o_data (d_chain[g+1])
        );
    end

    eq_compose #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_compose (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(v_chain[CORDIC_STAGES]),
        .i_data (d_chain[CORDIC_STAGES]),
        .o_valid(n_out_valid),
        .o_quat (m_axis_tdata)
    );

    assign m_axis_tvalid = n_out_valid;

    `EQ_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
    `EQ_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready,
        "input blocked with empty output")
    `EQ_ASSERT_IMP(a_w_range, i_clk, i_rst_n, m_axis_tvalid,
        ($signed(m_axis_tdata[15:0]) <= 16'sd16384) &&
        ($signed(m_axis_tdata[15:0]) >= -16'sd16384), "quat_w beyond one")

endmodule
